// ===== design/cbm_irq_pkg.sv =====
`timescale 1ns / 1ps

package cbm_irq_pkg;

  typedef enum logic [1:0] {
    OP_BUS_WRITE = 2'd0,
    OP_TICK      = 2'd1,
    OP_PRG_LOOK  = 2'd2,
    OP_CHR_LOOK  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [15:0]       address;
    logic [7:0]        data;
    logic signed [9:0] scanline;
    logic              rendering_on;
  } item_t;

  typedef struct packed {
    logic       irq_pulse;
    logic [7:0] mapped_bank;
    logic       mirror_horizontal;
  } result_t;

  localparam logic [7:0]  ADDR_OUTER_PAGE = 8'h41;
  localparam logic [15:0] ADDR_SELECT     = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DATA  = 16'h8001;
  localparam logic [15:0] ADDR_MIRROR     = 16'hA000;
  localparam logic [15:0] ADDR_IRQ_COUNT  = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_OFF    = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ON     = 16'hE001;

  localparam logic [7:0] SEL_CHR_PAIR0 = 8'h40;
  localparam logic [7:0] SEL_CHR_PAIR1 = 8'h41;
  localparam logic [7:0] SEL_CHR4      = 8'h42;
  localparam logic [7:0] SEL_CHR5      = 8'h43;
  localparam logic [7:0] SEL_CHR6      = 8'h44;
  localparam logic [7:0] SEL_CHR7      = 8'h45;
  localparam logic [7:0] SEL_PRG2      = 8'h46;
  localparam logic [7:0] SEL_PRG1      = 8'h47;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

  localparam int PRG_SLOTS = 4;
  localparam int CHR_SLOTS = 8;

endpackage

// ===== design/cbm_irq_if.sv =====
`timescale 1ns / 1ps

interface cbm_irq_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [15:0]       address;
  logic [7:0]        data;
  logic signed [9:0] scanline;
  logic              rendering_on;

  modport source (output valid, opcode, address, data, scanline, rendering_on, input ready);
  modport sink (input valid, opcode, address, data, scanline, rendering_on, output ready);
endinterface

interface cbm_irq_rsp_if;
  logic       valid;
  logic       ready;
  logic       irq_pulse;
  logic [7:0] mapped_bank;
  logic       mirror_horizontal;

  modport source (output valid, irq_pulse, mapped_bank, mirror_horizontal, input ready);
  modport sink (input valid, irq_pulse, mapped_bank, mirror_horizontal, output ready);
endinterface

// ===== design/cbm_irq_banks.sv =====
`timescale 1ns / 1ps

module cbm_irq_banks (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  cbm_irq_pkg::item_t  item,
  output logic [7:0]          bank,
  output logic                mirror_next
);

  logic [7:0] prg_banks [cbm_irq_pkg::PRG_SLOTS];
  logic [7:0] chr_banks [cbm_irq_pkg::CHR_SLOTS];
  logic [7:0] prg_banks_next [cbm_irq_pkg::PRG_SLOTS];
  logic [7:0] chr_banks_next [cbm_irq_pkg::CHR_SLOTS];
  logic [7:0] select;
  logic [7:0] select_next;
  logic       mirror;
  logic       is_write;
  logic [7:0] data_plus_one;

  assign is_write      = fire && (item.opcode == cbm_irq_pkg::OP_BUS_WRITE);
  assign data_plus_one = item.data + 8'd1;

  always_comb begin
    prg_banks_next = prg_banks;
    chr_banks_next = chr_banks;
    select_next    = select;
    mirror_next    = mirror;
    if (is_write) begin
      if (item.address[15:8] == cbm_irq_pkg::ADDR_OUTER_PAGE) begin
        for (int i = 0; i < cbm_irq_pkg::PRG_SLOTS; i++) begin
          prg_banks_next[i] = {4'd0, item.data[5:4], 2'(i)};
        end
      end else if (item.address == cbm_irq_pkg::ADDR_SELECT) begin
        select_next = item.data;
      end else if (item.address == cbm_irq_pkg::ADDR_MIRROR) begin
        mirror_next = item.data[0];
      end else if (item.address == cbm_irq_pkg::ADDR_BANK_DATA) begin
        case (select)
          cbm_irq_pkg::SEL_CHR_PAIR0: begin
            chr_banks_next[0] = item.data;
            chr_banks_next[1] = data_plus_one;
          end
          cbm_irq_pkg::SEL_CHR_PAIR1: begin
            chr_banks_next[2] = item.data;
            chr_banks_next[3] = data_plus_one;
          end
          cbm_irq_pkg::SEL_CHR4: chr_banks_next[4] = item.data;
          cbm_irq_pkg::SEL_CHR5: chr_banks_next[5] = item.data;
          cbm_irq_pkg::SEL_CHR6: chr_banks_next[6] = item.data;
          cbm_irq_pkg::SEL_CHR7: chr_banks_next[7] = item.data;
          cbm_irq_pkg::SEL_PRG2: prg_banks_next[2] = item.data;
          cbm_irq_pkg::SEL_PRG1: prg_banks_next[1] = item.data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    bank = 8'd0;
    case (item.opcode)
      cbm_irq_pkg::OP_PRG_LOOK: begin
        if (item.address[15]) begin
          bank = prg_banks[item.address[14:13]];
        end
      end
      cbm_irq_pkg::OP_CHR_LOOK: begin
        if (item.address[15:13] == 3'd0) begin
          bank = chr_banks[item.address[12:10]];
        end
      end
      default: bank = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbm_irq_pkg::PRG_SLOTS; i++) begin
        prg_banks[i] <= 8'(i);
      end
      for (int i = 0; i < cbm_irq_pkg::CHR_SLOTS; i++) begin
        chr_banks[i] <= 8'(i);
      end
      select <= 8'd0;
      mirror <= 1'b0;
    end else begin
      prg_banks <= prg_banks_next;
      chr_banks <= chr_banks_next;
      select    <= select_next;
      mirror    <= mirror_next;
    end
  end

endmodule

// ===== design/cbm_irq_counter.sv =====
`timescale 1ns / 1ps

module cbm_irq_counter (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  cbm_irq_pkg::item_t  item,
  output logic                pulse
);

  logic [7:0] count;
  logic [7:0] count_next;
  logic [7:0] reload;
  logic [7:0] reload_next;
  logic       enable;
  logic       enable_next;
  logic [7:0] count_dec;
  logic       counts;
  logic       is_write;

  assign is_write  = fire && (item.opcode == cbm_irq_pkg::OP_BUS_WRITE);
  assign count_dec = count - 8'd1;
  assign counts    = (item.opcode == cbm_irq_pkg::OP_TICK) && enable
                  && !item.scanline[9]
                  && (item.scanline[8:0] <= cbm_irq_pkg::LAST_VISIBLE_LINE)
                  && item.rendering_on;
  assign pulse     = counts && (count_dec == 8'd0);

  always_comb begin
    count_next  = count;
    reload_next = reload;
    enable_next = enable;
    if (is_write) begin
      if (item.address == cbm_irq_pkg::ADDR_IRQ_COUNT) begin
        count_next = item.data;
      end else if (item.address == cbm_irq_pkg::ADDR_IRQ_RELOAD) begin
        reload_next = item.data;
      end else if (item.address == cbm_irq_pkg::ADDR_IRQ_OFF) begin
        enable_next = 1'b0;
      end else if (item.address == cbm_irq_pkg::ADDR_IRQ_ON) begin
        enable_next = 1'b1;
      end
    end else if (fire && counts) begin
      count_next = pulse ? reload : count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 8'd0;
      reload <= 8'd0;
      enable <= 1'b0;
    end else begin
      count  <= count_next;
      reload <= reload_next;
      enable <= enable_next;
    end
  end

endmodule

// ===== design/cartridge_bank_mapper_irq.sv =====
`timescale 1ns / 1ps

// Bank mapper with a scanline interrupt counter. Each request word is a bus write, a scanline
// tick or a program or character bank lookup, and each one returns exactly one response word
// with the interrupt pulse, the looked-up bank and the mirroring in effect after the request.
// A request is captured in an input register, then decoded and applied to the mapper state as it
// moves on, and its response is held in an output register, so a new request is accepted every
// cycle while responses are taken; the response word is valid once its request leaves the input
// register, and only a response that waits for rsp.ready holds back the next request.

module cartridge_bank_mapper_irq (
  input logic           clk,
  input logic           rst,
  cbm_irq_req_if.sink   req,
  cbm_irq_rsp_if.source rsp
);

  logic                 stage_valid;
  cbm_irq_pkg::item_t   stage_item;
  logic                 out_valid;
  cbm_irq_pkg::result_t out_result;
  logic                 advance;
  logic                 pulse;
  logic [7:0]           bank;
  logic                 mirror_next;

  assign advance   = stage_valid && (!out_valid || rsp.ready);
  assign req.ready = !stage_valid || advance;

  cbm_irq_banks u_banks (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .item        (stage_item),
    .bank        (bank),
    .mirror_next (mirror_next)
  );

  cbm_irq_counter u_counter (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .item  (stage_item),
    .pulse (pulse)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (req.ready) begin
        stage_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_item.opcode       <= cbm_irq_pkg::opcode_t'(req.opcode);
      stage_item.address      <= req.address;
      stage_item.data         <= req.data;
      stage_item.scanline     <= req.scanline;
      stage_item.rendering_on <= req.rendering_on;
    end
    if (advance) begin
      out_result.irq_pulse         <= pulse;
      out_result.mapped_bank       <= bank;
      out_result.mirror_horizontal <= mirror_next;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.irq_pulse         = out_result.irq_pulse;
  assign rsp.mapped_bank       = out_result.mapped_bank;
  assign rsp.mirror_horizontal = out_result.mirror_horizontal;

endmodule

// ===== tb/cbm_irq_checker.sv =====
`timescale 1ns / 1ps

module cbm_irq_checker
  import cbm_irq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  cbm_irq_req_if req,
  cbm_irq_rsp_if rsp,
  output int     mismatches,
  output int     outstanding,
  output int     checked,
  output int     pulses
);

  logic [7:0] prg_bank [PRG_SLOTS];
  logic [7:0] chr_bank [CHR_SLOTS];
  logic [7:0] reg_sel;
  logic       mirror_h;
  logic [7:0] irq_count;
  logic [7:0] irq_reload;
  logic       irq_on;

  result_t expected_words [$];
  int      errors;
  int      n_checked;
  int      n_pulses;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %0d at %0t ns: %s is %0d, expected %0d", errors, $time, what, got, want);
  endtask

  task automatic clear_mapper();
    int i;
    for (i = 0; i < PRG_SLOTS; i++) prg_bank[i] = 8'(i);
    for (i = 0; i < CHR_SLOTS; i++) chr_bank[i] = 8'(i);
    reg_sel    = '0;
    mirror_h   = 1'b0;
    irq_count  = '0;
    irq_reload = '0;
    irq_on     = 1'b0;
  endtask

  task automatic map_request(input item_t w, output result_t r);
    int i;
    int line;
    r    = '0;
    line = $signed(w.scanline);
    case (w.opcode)
      OP_BUS_WRITE: begin
        if (w.address[15:8] == ADDR_OUTER_PAGE) begin
          for (i = 0; i < PRG_SLOTS; i++) prg_bank[i] = {4'd0, w.data[5:4], 2'(i)};
        end else begin
          case (w.address)
            ADDR_SELECT:     reg_sel = w.data;
            ADDR_BANK_DATA: begin
              case (reg_sel)
                SEL_CHR_PAIR0: begin
                  chr_bank[0] = w.data;
                  chr_bank[1] = w.data + 8'd1;
                end
                SEL_CHR_PAIR1: begin
                  chr_bank[2] = w.data;
                  chr_bank[3] = w.data + 8'd1;
                end
                SEL_CHR4: chr_bank[4] = w.data;
                SEL_CHR5: chr_bank[5] = w.data;
                SEL_CHR6: chr_bank[6] = w.data;
                SEL_CHR7: chr_bank[7] = w.data;
                SEL_PRG2: prg_bank[2] = w.data;
                SEL_PRG1: prg_bank[1] = w.data;
                default: ;
              endcase
            end
            ADDR_MIRROR:     mirror_h = w.data[0];
            ADDR_IRQ_COUNT:  irq_count = w.data;
            ADDR_IRQ_RELOAD: irq_reload = w.data;
            ADDR_IRQ_OFF:    irq_on = 1'b0;
            ADDR_IRQ_ON:     irq_on = 1'b1;
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (irq_on && line >= 0 && line <= int'(LAST_VISIBLE_LINE) && w.rendering_on) begin
          irq_count = irq_count - 8'd1;
          if (irq_count == 8'd0) begin
            irq_count   = irq_reload;
            r.irq_pulse = 1'b1;
          end
        end
      end
      OP_PRG_LOOK: begin
        if (w.address[15]) r.mapped_bank = prg_bank[w.address[14:13]];
      end
      default: begin
        if (w.address[15:13] == 3'd0) r.mapped_bank = chr_bank[w.address[12:10]];
      end
    endcase
    r.mirror_horizontal = mirror_h;
  endtask

  always @(posedge clk) begin : watch
    item_t   w;
    result_t want;
    result_t got;
    if (rst) begin
      clear_mapper();
      expected_words.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.irq_pulse         = rsp.irq_pulse;
        got.mapped_bank       = rsp.mapped_bank;
        got.mirror_horizontal = rsp.mirror_horizontal;
        if (expected_words.size() == 0) begin
          report_mismatch("response word with no request pending", 1, 0);
        end else begin
          want = expected_words.pop_front();
          if (got.irq_pulse !== want.irq_pulse)
            report_mismatch("irq_pulse", got.irq_pulse, want.irq_pulse);
          if (got.mapped_bank !== want.mapped_bank)
            report_mismatch("mapped_bank", got.mapped_bank, want.mapped_bank);
          if (got.mirror_horizontal !== want.mirror_horizontal)
            report_mismatch("mirror_horizontal", got.mirror_horizontal,
                            want.mirror_horizontal);
          n_checked++;
          if (want.irq_pulse) n_pulses++;
        end
      end
      if (req.valid && req.ready) begin
        w.opcode       = opcode_t'(req.opcode);
        w.address      = req.address;
        w.data         = req.data;
        w.scanline     = req.scanline;
        w.rendering_on = req.rendering_on;
        map_request(w, want);
        expected_words.push_back(want);
      end
    end
    outstanding <= expected_words.size();
    mismatches  <= errors;
    checked     <= n_checked;
    pulses      <= n_pulses;
  end

endmodule

// ===== tb/cartridge_bank_mapper_irq_test.sv =====
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq_test;
  import cbm_irq_pkg::*;

  localparam int IDLE_LIMIT  = 500;
  localparam int RANDOM_ITEMS = 950;

  logic clk;
  logic rst;

  cbm_irq_req_if req ();
  cbm_irq_rsp_if rsp ();

  int mismatches;
  int outstanding;
  int checked;
  int pulses;

  int n_writes;
  int n_ticks;
  int n_lookups;
  int sent;
  int idle_cycles;
  bit tx_no_idle;
  bit rx_no_idle;

  cartridge_bank_mapper_irq i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  cbm_irq_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .pulses      (pulses)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic item_t noise_word();
    item_t w;
    w.opcode       = opcode_t'($urandom_range(0, 3));
    w.address      = 16'($urandom);
    w.data         = 8'($urandom);
    w.scanline     = 10'($urandom);
    w.rendering_on = 1'($urandom);
    return w;
  endfunction

  function automatic item_t bus_wr(input logic [15:0] a, input logic [7:0] d);
    item_t w;
    w         = noise_word();
    w.opcode  = OP_BUS_WRITE;
    w.address = a;
    w.data    = d;
    return w;
  endfunction

  function automatic item_t tick(input int line, input logic rend);
    item_t w;
    w              = noise_word();
    w.opcode       = OP_TICK;
    w.scanline     = 10'(line);
    w.rendering_on = rend;
    return w;
  endfunction

  function automatic item_t lookup(input opcode_t op, input logic [15:0] a);
    item_t w;
    w         = noise_word();
    w.opcode  = op;
    w.address = a;
    return w;
  endfunction

  function automatic item_t random_request();
    item_t w;
    int    pick;
    int    k;
    w    = noise_word();
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      w.opcode = OP_TICK;
      k        = $urandom_range(0, 9);
      if (k < 7) w.scanline = 10'($urandom_range(0, 239));
      else if (k < 9) w.scanline = 10'(int'($urandom_range(0, 262)) - 1);
      w.rendering_on = ($urandom_range(0, 7) != 0);
    end else if (pick < 42) begin
      w.opcode = OP_PRG_LOOK;
      if ($urandom_range(0, 3) != 0) w.address[15] = 1'b1;
    end else if (pick < 54) begin
      w.opcode = OP_CHR_LOOK;
      if ($urandom_range(0, 3) != 0) w.address[15:13] = 3'd0;
    end else begin
      w.opcode = OP_BUS_WRITE;
      k        = $urandom_range(0, 11);
      case (k)
        0: w.address = {ADDR_OUTER_PAGE, 8'($urandom)};
        1: begin
          w.address = ADDR_SELECT;
          if ($urandom_range(0, 3) != 0) w.data = SEL_CHR_PAIR0 + 8'($urandom_range(0, 7));
        end
        2, 3: w.address = ADDR_BANK_DATA;
        4: w.address = ADDR_MIRROR;
        5: begin
          w.address = ADDR_IRQ_COUNT;
          if ($urandom_range(0, 3) != 0) w.data = 8'($urandom_range(0, 6));
        end
        6: begin
          w.address = ADDR_IRQ_RELOAD;
          if ($urandom_range(0, 3) != 0) w.data = 8'($urandom_range(0, 6));
        end
        7: w.address = ADDR_IRQ_OFF;
        8, 9: w.address = ADDR_IRQ_ON;
        10: w.address = ADDR_BANK_DATA ^ (16'd1 << $urandom_range(0, 15));
        default: ;
      endcase
    end
    return w;
  endfunction

  task automatic send_word(input item_t w);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.opcode       <= w.opcode;
    req.address      <= w.address;
    req.data         <= w.data;
    req.scanline     <= w.scanline;
    req.rendering_on <= w.rendering_on;
    do @(posedge clk); while (!req.ready);
    sent++;
    case (w.opcode)
      OP_BUS_WRITE: n_writes++;
      OP_TICK:      n_ticks++;
      default:      n_lookups++;
    endcase
  endtask

  task automatic drain_responses();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    req.valid        <= 1'b0;
    req.opcode       <= OP_BUS_WRITE;
    req.address      <= '0;
    req.data         <= '0;
    req.scanline     <= '0;
    req.rendering_on <= 1'b0;
    rst              <= 1'b1;
    n_writes   = 0;
    n_ticks    = 0;
    n_lookups  = 0;
    sent       = 0;
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(lookup(OP_PRG_LOOK, 16'h8000));
    send_word(lookup(OP_PRG_LOOK, 16'hFFFF));
    send_word(lookup(OP_PRG_LOOK, 16'h7FFF));
    send_word(lookup(OP_CHR_LOOK, 16'h1FFF));
    send_word(lookup(OP_CHR_LOOK, 16'h2000));
    send_word(bus_wr({ADDR_OUTER_PAGE, 8'h00}, 8'hFF));
    send_word(lookup(OP_PRG_LOOK, 16'hA000));
    send_word(bus_wr({ADDR_OUTER_PAGE, 8'hFF}, 8'h00));
    send_word(bus_wr(ADDR_SELECT, SEL_CHR_PAIR0));
    send_word(bus_wr(ADDR_BANK_DATA, 8'hFF));
    send_word(lookup(OP_CHR_LOOK, 16'h0400));
    send_word(bus_wr(ADDR_SELECT, SEL_PRG1));
    send_word(bus_wr(ADDR_BANK_DATA, 8'hA5));
    send_word(bus_wr(ADDR_SELECT, 8'hFF));
    send_word(bus_wr(ADDR_BANK_DATA, 8'h00));
    send_word(bus_wr(16'hFFFF, 8'hFF));
    send_word(bus_wr(ADDR_MIRROR, 8'hFF));
    send_word(bus_wr(ADDR_IRQ_COUNT, 8'd2));
    send_word(bus_wr(ADDR_IRQ_RELOAD, 8'd1));
    send_word(tick(0, 1'b1));
    send_word(bus_wr(ADDR_IRQ_ON, 8'h00));
    send_word(tick(-1, 1'b1));
    send_word(tick(240, 1'b1));
    send_word(tick(0, 1'b0));
    send_word(tick(0, 1'b1));
    send_word(tick(239, 1'b1));
    send_word(bus_wr(ADDR_IRQ_COUNT, 8'd0));
    send_word(tick(100, 1'b1));
    send_word(bus_wr(ADDR_IRQ_OFF, 8'h00));
    drain_responses();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 100 == 0) begin
        tx_no_idle = ($urandom_range(0, 3) == 0);
        rx_no_idle = ($urandom_range(0, 3) == 0);
      end
      if (sent >= 500 && sent < 502) drain_responses();
      if ($urandom_range(0, 3) == 0) begin
        send_word(bus_wr(ADDR_SELECT, SEL_CHR_PAIR0 + 8'($urandom_range(0, 7))));
        send_word(bus_wr(ADDR_BANK_DATA, 8'($urandom)));
      end else begin
        send_word(random_request());
      end
    end

    drain_responses();
    repeat (8) @(posedge clk);
    $display("Sent %0d bus writes, %0d scanline ticks and %0d bank lookups.",
             n_writes, n_ticks, n_lookups);
    $display("Compared %0d response words, %0d of them with an interrupt pulse.",
             checked, pulses);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : response_side
    int stall;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a word moving.", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
design/cbm_irq_pkg.sv
design/cbm_irq_if.sv
design/cbm_irq_banks.sv
design/cbm_irq_counter.sv
design/cartridge_bank_mapper_irq.sv
tb/cbm_irq_checker.sv
tb/cartridge_bank_mapper_irq_test.sv
